FILE: rtl/lkv_pkg.sv
// lkv_pkg: sizes, command codes, controller states and the neighbor link
// type shared by the cells, the top level and the checker
// no dependencies

package lkv_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int CFG_BITS    = 5;
    localparam int OUT_BITS    = 32;
    localparam int IDX_BITS    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_RESET   = 16;

    typedef enum logic
    {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

    typedef enum logic
    {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // what one cell hands to the next one down the row
    typedef struct packed
    {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } cell_link_t;

endpackage

FILE: rtl/lru_key_value_cache.sv
// lru_key_value_cache: top level, controller, occupancy count and the row of cells
// depends on lkv_pkg and lkv_cell

// A fully associative key/value store of up to sixteen entries held in a row of
// cells in recency order, cell 0 being the most recent. The beat is captured in the
// idle state; in the exec state every cell compares its key with the probe while
// the row shifts one place toward the back up to the hit or insert point. The exec
// state waits while an earlier result is still stalled on the output, and no new
// beat is taken until it is left. A new beat is accepted while a result still waits
// on the output. The valid marks and the occupancy count clear at reset; there is
// no clearing pass. capacity_limit may only be written while the block is idle.

module lru_key_value_cache
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [lkv_pkg::CFG_BITS-1:0]         cfg_wr_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 cmd,
    input  logic signed [lkv_pkg::KEY_BITS-1:0]  lookup_key,
    input  logic signed [lkv_pkg::VALUE_BITS-1:0] write_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 hit,
    output logic signed [lkv_pkg::OUT_BITS-1:0]  read_value,
    output logic                                 evicted
);

    lkv_pkg::state_t                 state_reg, state_next;
    logic [lkv_pkg::CFG_BITS-1:0]    capacity_limit_reg;
    logic [lkv_pkg::CNT_BITS-1:0]    occupancy_reg, occupancy_next;
    lkv_pkg::cmd_t                   op_cmd_reg;
    logic [lkv_pkg::KEY_BITS-1:0]    op_key_reg;
    logic [lkv_pkg::VALUE_BITS-1:0]  op_value_reg;
    logic                            out_valid_reg;
    logic                            hit_reg, hit_next;
    logic [lkv_pkg::OUT_BITS-1:0]    read_value_reg, read_value_next;
    logic                            evicted_reg, evicted_next;

    logic                            exec_go;
    logic                            accept;
    logic [lkv_pkg::MAX_ENTRIES-1:0] match;
    logic [lkv_pkg::MAX_ENTRIES-1:0] shift;
    logic [lkv_pkg::IDX_BITS-1:0]    pos;
    logic [lkv_pkg::IDX_BITS-1:0]    last;
    logic                            any_hit;
    logic                            do_update;
    logic                            full;
    logic [lkv_pkg::CNT_BITS-1:0]    cap_eff;
    logic [lkv_pkg::VALUE_BITS-1:0]  sel_value;
    lkv_pkg::cell_link_t             front_link;
    lkv_pkg::cell_link_t             links [lkv_pkg::MAX_ENTRIES];

    assign accept = in_valid && in_ready;

    // controller
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lkv_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        exec_go    = 1'b0;
        case (state_reg)
            lkv_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = lkv_pkg::ST_EXEC;
                end
            end
            lkv_pkg::ST_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    exec_go    = 1'b1;
                    state_next = lkv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    // capture of the input beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_cmd_reg   <= lkv_pkg::cmd_t'(cmd);
            op_key_reg   <= lookup_key;
            op_value_reg <= write_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_limit_reg <= lkv_pkg::CFG_BITS'(lkv_pkg::CAP_RESET);
        end
        else if (cfg_wr_en)
        begin
            capacity_limit_reg <= cfg_wr_data;
        end
    end

    // lookup and shift decision
    always_comb
    begin
        if (capacity_limit_reg == '0)
        begin
            cap_eff = lkv_pkg::CNT_BITS'(1);
        end
        else if (32'(capacity_limit_reg) > lkv_pkg::MAX_ENTRIES)
        begin
            cap_eff = lkv_pkg::CNT_BITS'(lkv_pkg::MAX_ENTRIES);
        end
        else
        begin
            cap_eff = lkv_pkg::CNT_BITS'(capacity_limit_reg);
        end
    end

    always_comb
    begin
        pos = '0;
        for (int i = lkv_pkg::MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                pos = lkv_pkg::IDX_BITS'(i);
            end
        end
    end

    always_comb
    begin
        sel_value = '0;
        for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
        begin
            if (pos == lkv_pkg::IDX_BITS'(i))
            begin
                sel_value = links[i].value;
            end
        end
    end

    assign any_hit = |match;
    assign full    = (occupancy_reg >= cap_eff);

    always_comb
    begin
        do_update       = 1'b0;
        last            = '0;
        occupancy_next  = occupancy_reg;
        hit_next        = any_hit;
        read_value_next = '1;
        evicted_next    = 1'b0;
        front_link.valid = 1'b1;
        front_link.key   = op_key_reg;
        front_link.value = op_value_reg;
        if (any_hit)
        begin
            do_update = 1'b1;
            last      = pos;
            if (op_cmd_reg == lkv_pkg::CMD_GET)
            begin
                front_link.value = sel_value;
                read_value_next  = lkv_pkg::OUT_BITS'(sel_value);
            end
        end
        else if (op_cmd_reg == lkv_pkg::CMD_PUT)
        begin
            do_update = 1'b1;
            if (full)
            begin
                last         = lkv_pkg::IDX_BITS'(occupancy_reg - 1'b1);
                evicted_next = 1'b1;
            end
            else
            begin
                last           = lkv_pkg::IDX_BITS'(occupancy_reg);
                occupancy_next = occupancy_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
        begin
            shift[i] = exec_go && do_update && (i <= int'(last));
        end
    end

    // row of cells
    for (genvar g = 0; g < lkv_pkg::MAX_ENTRIES; g++)
    begin : g_cell
        lkv_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (shift[g]),
            .probe_key (op_key_reg),
            .prev_link ((g == 0) ? front_link : links[(g == 0) ? 0 : g - 1]),
            .link      (links[g]),
            .match     (match[g])
        );
    end

    // occupancy and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupancy_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec_go)
            begin
                occupancy_reg <= occupancy_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            hit_reg        <= hit_next;
            read_value_reg <= read_value_next;
            evicted_reg    <= evicted_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;
    assign evicted    = evicted_reg;

endmodule

FILE: rtl/lkv_cell.sv
// lkv_cell: one slot of the recency row, holding a key, a value and a valid mark
// compares its key with the probe and loads its upper neighbor on shift
// depends on lkv_pkg

module lkv_cell
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                shift,
    input  logic [lkv_pkg::KEY_BITS-1:0]        probe_key,
    input  lkv_pkg::cell_link_t                 prev_link,
    output lkv_pkg::cell_link_t                 link,
    output logic                                match
);

    logic                          valid_reg;
    logic [lkv_pkg::KEY_BITS-1:0]   key_reg;
    logic [lkv_pkg::VALUE_BITS-1:0] value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= prev_link.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg   <= prev_link.key;
            value_reg <= prev_link.value;
        end
    end

    assign match       = valid_reg && (key_reg == probe_key);
    assign link.valid  = valid_reg;
    assign link.key    = key_reg;
    assign link.value  = value_reg;

endmodule

FILE: rtl/lkv_checker.sv
// lkv_checker: port-level assertions for lru_key_value_cache and its bind
// depends on lkv_pkg and lru_key_value_cache

module lkv_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic                                 hit,
    input logic signed [lkv_pkg::OUT_BITS-1:0]  read_value,
    input logic                                 evicted
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(read_value)
            && $stable(evicted))
        else $error("result beat changed while stalled");

    // an eviction only follows a put miss
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> !hit)
        else $error("eviction reported on a hit");

    // a miss returns all ones
    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> read_value == '1)
        else $error("miss returned a value other than all ones");

    // no back to back accepts: in_ready drops after an accept
    a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an operation is in progress");

    // a free output gets the result in the cycle after the exec cycle
    a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 !out_valid |=> out_valid)
        else $error("result missing after exec cycle");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .read_value (read_value),
    .evicted    (evicted)
);
